>>> src/assert_macros.svh
// Assertion macros used by the top level of the timer block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Immediate implication: the consequent must hold in the same cycle.
`define ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication: the consequent must hold in the next cycle.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/dtt_pkg.sv
// Package with the constants, types and functions of the timer block.
`timescale 1ns / 1ps

package dtt_pkg;

  localparam int unsigned CyclesW   = 8;
  localparam int unsigned CountW    = 8;
  localparam int unsigned DividerW  = 16;
  localparam int unsigned PrescaleW = 11;
  localparam int unsigned AccW      = 12;
  localparam int unsigned DelayW    = 3;
  localparam int unsigned CtrlW     = 3;
  localparam int unsigned CfgDataW  = 8;
  localparam int unsigned CfgIdxW   = 1;

  localparam logic [CtrlW-1:0]   CTRL_ENABLE  = 3'h4;
  localparam logic [CtrlW-1:0]   CTRL_RATE    = 3'h3;
  localparam logic [CountW-1:0]  COUNT_MAX    = 8'hFF;
  localparam logic [DelayW-1:0]  RELOAD_DELAY = 3'd4;

  localparam logic [CfgIdxW-1:0] REG_TIMER_CONTROL = 1'b0;
  localparam logic [CfgIdxW-1:0] REG_RELOAD_VALUE  = 1'b1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;    // take the input transaction and start the item
    logic step;    // one whole period out of the accumulator
    logic finish;  // capture the result; store the prescaler when enabled
  } dtt_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic more;    // counting enabled and another whole period is held
  } dtt_sts_t;

  // Period in machine cycles for a rate selection: 2 << {9, 3, 5, 7}.
  function automatic logic [AccW-1:0] rate_period(input logic [1:0] rate);
    logic [AccW-1:0] p;
    case (rate)
      2'd0:    p = 12'd1024;
      2'd1:    p = 12'd16;
      2'd2:    p = 12'd64;
      2'd3:    p = 12'd256;
      default: p = 12'd1024;
    endcase
    return p;
  endfunction

endpackage

>>> src/dtt_in_if.sv
// Input channel interface: elapsed cycles and the counter-written flag.
`timescale 1ns / 1ps

interface dtt_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] elapsed_cycles;
  logic       counter_written;

  modport source (output valid, output elapsed_cycles, output counter_written,
                  input ready);
  modport sink   (input valid, input elapsed_cycles, input counter_written,
                  output ready);
endinterface

>>> src/dtt_out_if.sv
// Result channel interface: counter, divider high byte and interrupt flag.
`timescale 1ns / 1ps

interface dtt_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] counter_value;
  logic [7:0] divider_value;
  logic       timer_irq;

  modport source (output valid, output counter_value, output divider_value,
                  output timer_irq, input ready);
  modport sink   (input valid, input counter_value, input divider_value,
                  input timer_irq, output ready);
endinterface

>>> src/dtt_ctrl.sv
// Controller state machine that sequences the timer datapath.
`timescale 1ns / 1ps

module dtt_ctrl
  import dtt_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  input  dtt_sts_t sts,
  output dtt_cmd_t cmd
);

  typedef enum logic [0:0] {
    S_IDLE,
    S_LOOP
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_free  = !out_valid_r || out_ready;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_LOOP;
        end
      end
      S_LOOP: begin
        if (sts.more) begin
          cmd.step = 1'b1;
        end else if (out_free) begin
          // The result register is free this cycle, so the item can retire.
          cmd.finish    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

>>> src/dtt_datapath.sv
// Datapath of the timer: configuration, counters, prescaler and result register.
`timescale 1ns / 1ps

module dtt_datapath
  import dtt_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_data,
  input  logic [CyclesW-1:0]  elapsed_cycles,
  input  logic                counter_written,
  input  dtt_cmd_t            cmd,
  output dtt_sts_t            sts,
  output logic [CountW-1:0]   counter_value,
  output logic [7:0]          divider_value,
  output logic                timer_irq
);

  logic [CtrlW-1:0]     ctrl_r;
  logic [CountW-1:0]    reload_r;
  logic [DividerW-1:0]  divider_r;
  logic [PrescaleW-1:0] prescale_r;
  logic [CountW-1:0]    timer_r;
  logic [DelayW-1:0]    delay_r;
  logic [AccW-1:0]      acc_r;
  logic                 irq_r;
  logic [CountW-1:0]    res_count_r;
  logic [7:0]           res_div_r;
  logic                 res_irq_r;

  logic                 enabled;
  logic [AccW-1:0]      period;
  logic                 delay_done;

  assign enabled    = (ctrl_r & CTRL_ENABLE) != '0;
  assign period     = rate_period(ctrl_r[1:0]);
  assign sts.more   = enabled && (acc_r >= period);
  assign delay_done = ({{(CyclesW-DelayW){1'b0}}, delay_r} <= elapsed_cycles);

  assign counter_value = res_count_r;
  assign divider_value = res_div_r;
  assign timer_irq     = res_irq_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctrl_r     <= '0;
      reload_r   <= '0;
      divider_r  <= '0;
      prescale_r <= '0;
      timer_r    <= '0;
      delay_r    <= '0;
      irq_r      <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_TIMER_CONTROL: ctrl_r   <= cfg_data[CtrlW-1:0];
          REG_RELOAD_VALUE:  reload_r <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.load) begin
        // A pending reload delay is served before any counting.
        irq_r <= 1'b0;
        if (delay_r != '0) begin
          if (delay_done) begin
            delay_r <= '0;
            irq_r   <= 1'b1;
            if (!counter_written) begin
              timer_r <= reload_r;
            end
          end else begin
            delay_r <= delay_r - elapsed_cycles[DelayW-1:0];
          end
        end
        divider_r <= divider_r + {{(DividerW-CyclesW){1'b0}}, elapsed_cycles};
      end
      if (cmd.step) begin
        timer_r <= timer_r + 1'b1;
        if (timer_r == COUNT_MAX) begin
          delay_r <= RELOAD_DELAY;
        end
      end
      if (cmd.finish && enabled) begin
        prescale_r <= acc_r[PrescaleW-1:0];
      end
    end
  end

  // Accumulator and result register carry payload only.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      acc_r <= {1'b0, prescale_r} + {{(AccW-CyclesW){1'b0}}, elapsed_cycles};
    end else if (cmd.step) begin
      acc_r <= acc_r - period;
    end
    if (cmd.finish) begin
      res_count_r <= timer_r;
      res_div_r   <= divider_r[DividerW-1:DividerW-8];
      res_irq_r   <= irq_r;
    end
  end

endmodule

>>> src/div_tima_timer_step.sv
// Top level of the timer block: controller, datapath and channel wiring.
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Channel   Direction  Handshake      Payload
// in_ch     sink       valid/ready    elapsed_cycles[7:0], counter_written
// out_ch    source     valid/ready    counter_value[7:0], divider_value[7:0], timer_irq
// cfg_*     write      cfg_we         cfg_index[0], cfg_data[7:0]
//
// An item is loaded, steps the counter N times and retires, where N is the number of
// whole timer periods held in the prescaler plus the elapsed cycles; the counter steps
// once per cycle of the loop; N reaches 79 at most and is about 16 at a period of 16.
// Reset is synchronous and active low and clears all timer state but the accumulator and result register.
// The result waits in an output register; the next transaction is taken while
// it waits, and an item only stalls at its end if that register is still full.

module div_tima_timer_step
  import dtt_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  dtt_in_if.sink              in_ch,
  dtt_out_if.source           out_ch,
  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_data
);

  dtt_cmd_t cmd;
  dtt_sts_t sts;

  // The controller owns the handshakes and issues at most one command per cycle.
  dtt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // The datapath holds the configuration, all timer state and the result.
  dtt_datapath u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .elapsed_cycles  (in_ch.elapsed_cycles),
    .counter_written (in_ch.counter_written),
    .cmd             (cmd),
    .sts             (sts),
    .counter_value   (out_ch.counter_value),
    .divider_value   (out_ch.divider_value),
    .timer_irq       (out_ch.timer_irq)
  );

  // After a transaction is taken, the block is busy in the next cycle.
  `ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_ch.valid && in_ch.ready, !in_ch.ready, "input accepted while an item is in progress")
  // A new result only appears when an item retires from the counting loop.
  `ASSERT_SAME(a_result_from_loop, clk, rst_n, $rose(out_ch.valid), $past(!in_ch.ready), "result produced without an item in progress")
  // Commands to the datapath are mutually exclusive.
  `ASSERT_SAME(a_cmd_onehot, clk, rst_n, 1'b1, $onehot0(cmd), "more than one datapath command in a cycle")

endmodule
